@@ rtl/ufe_pkg.sv @@
// shared types and constants for the union-find engine
// used by union_find_engine_top; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package ufe_pkg;

  localparam int NODES_DEF = 256;
  localparam int NODE_W    = 8;
  localparam int SIZE_W    = 9;
  localparam int RANK_W    = 4;

  localparam logic [SIZE_W-1:0] SIZE_MAX = '1;
  localparam logic [RANK_W-1:0] RANK_MAX = '1;

  localparam logic OP_QUERY = 1'b0;
  localparam logic OP_UNION = 1'b1;

  localparam logic MODE_SIZE = 1'b0;
  localparam logic MODE_RANK = 1'b1;

  // per-root bookkeeping, kept together in one memory word
  typedef struct packed {
    logic [SIZE_W-1:0] size;
    logic [RANK_W-1:0] rank;
  } aux_t;

  localparam aux_t AUX_RESET = '{size: SIZE_W'(1), rank: '0};

endpackage

`default_nettype wire

@@ rtl/ufe_ram.sv @@
// generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module ufe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

@@ rtl/union_find_engine_top.sv @@
// union-find engine: parent links and per-root size/rank kept in two rams
// depends on ufe_pkg and ufe_ram
// steps: accept, index reduction by subtraction while out of range, walk of node_a to its root,
//   compress of that path, same again for node_b, two aux steps for a union, then the result;
//   one parent-ram read per step sets the pace
// throughput: one word in flight; a new word is taken while the last result waits
// reset: a clearing pass rewrites every entry of both rams; no word is taken until done
`timescale 1ns / 1ps
`default_nettype none

module union_find_engine_top #(
  parameter int NODES = ufe_pkg::NODES_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      cfg_wr_en,
  input  wire logic                      cfg_wr_data,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic                      in_op,
  input  wire logic [ufe_pkg::NODE_W-1:0] in_node_a,
  input  wire logic [ufe_pkg::NODE_W-1:0] in_node_b,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic      [ufe_pkg::NODE_W-1:0] out_root_a,
  output logic      [ufe_pkg::NODE_W-1:0] out_root_b,
  output logic                           out_same_set,
  output logic      [ufe_pkg::NODE_W-1:0] out_final_root
);

  localparam int IDX_W = $clog2(NODES);
  localparam int CW    = ((IDX_W > ufe_pkg::NODE_W) ? IDX_W : ufe_pkg::NODE_W) + 1;
  localparam int AUX_W = $bits(ufe_pkg::aux_t);

  typedef enum logic [9:0] {
    S_INIT   = 10'b00_0000_0001,
    S_IDLE   = 10'b00_0000_0010,
    S_REDUCE = 10'b00_0000_0100,
    S_WALK_A = 10'b00_0000_1000,
    S_COMP_A = 10'b00_0001_0000,
    S_WALK_B = 10'b00_0010_0000,
    S_COMP_B = 10'b00_0100_0000,
    S_AUX_A  = 10'b00_1000_0000,
    S_AUX_B  = 10'b01_0000_0000,
    S_DONE   = 10'b10_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  logic [IDX_W-1:0] clr_cnt_r, clr_cnt_nxt;
  logic             mode_r;
  logic             op_r, op_nxt;
  logic [ufe_pkg::NODE_W-1:0] a_r, a_nxt, b_r, b_nxt;
  logic [IDX_W-1:0] cur_r, cur_nxt;
  logic [IDX_W-1:0] cnode_r, cnode_nxt;
  logic [IDX_W-1:0] root_a_r, root_a_nxt, root_b_r, root_b_nxt;
  logic [IDX_W-1:0] fin_r, fin_nxt;
  logic             same_r, same_nxt;
  ufe_pkg::aux_t    aux_a_r, aux_a_nxt;

  logic                     out_valid_r;
  logic [ufe_pkg::NODE_W-1:0] out_root_a_r, out_root_b_r, out_final_root_r;
  logic                     out_same_set_r;
  logic                     out_free, out_load;

  // ram ports
  logic             p_we;
  logic [IDX_W-1:0] p_waddr, p_wdata, p_raddr, p_rdata;
  logic             x_we;
  logic [IDX_W-1:0] x_waddr, x_raddr;
  logic [AUX_W-1:0] x_wdata_raw, x_rdata_raw;
  ufe_pkg::aux_t    x_wdata, x_rdata;

  // union decision
  logic [IDX_W-1:0]           a_idx, b_idx;
  logic                       a_big, b_big;
  logic [ufe_pkg::SIZE_W:0]   size_sum;
  logic [ufe_pkg::SIZE_W-1:0] size_sat;
  logic                       a_wins;
  ufe_pkg::aux_t              win_aux;

  ufe_ram #(.WIDTH(IDX_W), .DEPTH(NODES)) u_parent_ram (
    .clk     (clk),
    .wr_en   (p_we),
    .wr_addr (p_waddr),
    .wr_data (p_wdata),
    .rd_addr (p_raddr),
    .rd_data (p_rdata)
  );

  ufe_ram #(.WIDTH(AUX_W), .DEPTH(NODES)) u_aux_ram (
    .clk     (clk),
    .wr_en   (x_we),
    .wr_addr (x_waddr),
    .wr_data (x_wdata_raw),
    .rd_addr (x_raddr),
    .rd_data (x_rdata_raw)
  );

  assign x_wdata_raw = x_wdata;
  assign x_rdata     = ufe_pkg::aux_t'(x_rdata_raw);

  assign in_stall = (state_r != S_IDLE);
  assign out_free = !out_valid_r || !out_stall;

  // node indices reduce by repeated subtraction, one step a cycle
  assign a_big = (CW'(a_r) >= CW'(NODES));
  assign b_big = (CW'(b_r) >= CW'(NODES));
  assign a_idx = IDX_W'(a_r);
  assign b_idx = IDX_W'(b_r);

  // link decision, using aux_a_r and the aux word of root_b on the read port
  always_comb begin
    size_sum = {1'b0, aux_a_r.size} + {1'b0, x_rdata.size};
    size_sat = (size_sum > {1'b0, ufe_pkg::SIZE_MAX}) ? ufe_pkg::SIZE_MAX
                                                      : size_sum[ufe_pkg::SIZE_W-1:0];
    if (mode_r == ufe_pkg::MODE_SIZE) begin
      a_wins = (x_rdata.size < aux_a_r.size);
      win_aux.size = size_sat;
      win_aux.rank = a_wins ? aux_a_r.rank : x_rdata.rank;
    end else begin
      a_wins = (x_rdata.rank < aux_a_r.rank);
      win_aux = a_wins ? aux_a_r : x_rdata;
      // equal ranks: root_b survives one rank higher, saturating at RANK_MAX
      if (aux_a_r.rank == x_rdata.rank && x_rdata.rank != ufe_pkg::RANK_MAX) begin
        win_aux.rank = x_rdata.rank + ufe_pkg::RANK_W'(1);
      end
    end
  end

  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    op_nxt      = op_r;
    a_nxt       = a_r;
    b_nxt       = b_r;
    cur_nxt     = cur_r;
    cnode_nxt   = cnode_r;
    root_a_nxt  = root_a_r;
    root_b_nxt  = root_b_r;
    fin_nxt     = fin_r;
    same_nxt    = same_r;
    aux_a_nxt   = aux_a_r;
    out_load    = 1'b0;

    p_we    = 1'b0;
    p_waddr = cnode_r;
    p_wdata = root_a_r;
    p_raddr = cur_r;
    x_we    = 1'b0;
    x_waddr = clr_cnt_r;
    x_wdata = ufe_pkg::AUX_RESET;
    x_raddr = root_a_r;

    case (state_r)
      S_INIT: begin
        p_we        = 1'b1;
        p_waddr     = clr_cnt_r;
        p_wdata     = clr_cnt_r;
        x_we        = 1'b1;
        clr_cnt_nxt = clr_cnt_r + IDX_W'(1);
        if (clr_cnt_r == IDX_W'(NODES - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          op_nxt    = in_op;
          a_nxt     = in_node_a;
          b_nxt     = in_node_b;
          state_nxt = S_REDUCE;
        end
      end
      S_REDUCE: begin
        if (a_big || b_big) begin
          if (a_big) a_nxt = a_r - ufe_pkg::NODE_W'(NODES);
          if (b_big) b_nxt = b_r - ufe_pkg::NODE_W'(NODES);
        end else begin
          cur_nxt   = a_idx;
          p_raddr   = a_idx;
          state_nxt = S_WALK_A;
        end
      end
      S_WALK_A: begin
        if (p_rdata == cur_r) begin
          root_a_nxt = cur_r;
          cnode_nxt  = a_idx;
          p_raddr    = a_idx;
          state_nxt  = S_COMP_A;
        end else begin
          cur_nxt = p_rdata;
          p_raddr = p_rdata;
        end
      end
      S_COMP_A: begin
        if (cnode_r == root_a_r) begin
          cur_nxt   = b_idx;
          p_raddr   = b_idx;
          state_nxt = S_WALK_B;
        end else begin
          // point this node at the root and step to its old parent
          p_we      = 1'b1;
          p_waddr   = cnode_r;
          p_wdata   = root_a_r;
          cnode_nxt = p_rdata;
          p_raddr   = p_rdata;
        end
      end
      S_WALK_B: begin
        if (p_rdata == cur_r) begin
          root_b_nxt = cur_r;
          cnode_nxt  = b_idx;
          p_raddr    = b_idx;
          state_nxt  = S_COMP_B;
        end else begin
          cur_nxt = p_rdata;
          p_raddr = p_rdata;
        end
      end
      S_COMP_B: begin
        if (cnode_r == root_b_r) begin
          same_nxt = (root_a_r == root_b_r);
          fin_nxt  = root_a_r;
          x_raddr  = root_a_r;
          if (op_r == ufe_pkg::OP_UNION && root_a_r != root_b_r) begin
            state_nxt = S_AUX_A;
          end else begin
            state_nxt = S_DONE;
          end
        end else begin
          p_we      = 1'b1;
          p_waddr   = cnode_r;
          p_wdata   = root_b_r;
          cnode_nxt = p_rdata;
          p_raddr   = p_rdata;
        end
      end
      S_AUX_A: begin
        aux_a_nxt = x_rdata;
        x_raddr   = root_b_r;
        state_nxt = S_AUX_B;
      end
      S_AUX_B: begin
        p_we      = 1'b1;
        p_waddr   = a_wins ? root_b_r : root_a_r;
        p_wdata   = a_wins ? root_a_r : root_b_r;
        x_we      = 1'b1;
        x_waddr   = a_wins ? root_a_r : root_b_r;
        x_wdata   = win_aux;
        fin_nxt   = a_wins ? root_a_r : root_b_r;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      clr_cnt_r   <= '0;
      mode_r      <= ufe_pkg::MODE_SIZE;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      if (cfg_wr_en) begin
        mode_r <= cfg_wr_data;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    a_r      <= a_nxt;
    b_r      <= b_nxt;
    cur_r    <= cur_nxt;
    cnode_r  <= cnode_nxt;
    root_a_r <= root_a_nxt;
    root_b_r <= root_b_nxt;
    fin_r    <= fin_nxt;
    same_r   <= same_nxt;
    aux_a_r  <= aux_a_nxt;
    if (out_load) begin
      out_root_a_r     <= ufe_pkg::NODE_W'(root_a_r);
      out_root_b_r     <= ufe_pkg::NODE_W'(root_b_r);
      out_same_set_r   <= same_r;
      out_final_root_r <= ufe_pkg::NODE_W'(fin_r);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_root_a     = out_root_a_r;
  assign out_root_b     = out_root_b_r;
  assign out_same_set   = out_same_set_r;
  assign out_final_root = out_final_root_r;

endmodule

`default_nettype wire
